>>> rtl/sfpv_pkg.sv
// Package for the SPI flash programmer: word types, opcodes and register indexes.
// No dependencies; imported by the top level, the checker and the testbench.
package sfpv_pkg;

  // Input word: one tick, one image byte delivery or a start request
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       miso;
  } sfpv_in_t;

  // Result word: pin levels and status after the item
  typedef struct packed {
    logic cs_n;
    logic sclk;
    logic mosi;
    logic want_byte;
    logic busy_res;
    logic done_res;
    logic verify_failed;
  } sfpv_out_t;

  // Actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Configuration register indexes
  localparam logic REG_IMAGE_LENGTH = 1'b0;
  localparam logic REG_POLL_GAP     = 1'b1;

  // Flash opcodes
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_SE    = 8'hD8;
  localparam logic [7:0] OP_PP    = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_RES   = 8'hAB;
  localparam logic [7:0] OP_DP    = 8'hB9;

  localparam logic [24:0] ADDR_LIMIT = 25'h100_0000;

endpackage

>>> rtl/sfpv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfpv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/spi_flash_program_verify.sv
// SPI NOR flash programmer: erase, page program and readback verify, one half-bit per tick.
// Depends on sfpv_pkg and sfpv_ram (page buffer).
// Results are registered in the output register, or in the skid register on a stall.
// Throughput: one word per cycle while in_stall is low; a two-entry output buffer takes
// one more word while a result waits. Reset (rst_n low, synchronous) returns to idle with
// cs_n high, sclk and mosi low; the page buffer is not cleared and needs no clearing pass.
module spi_flash_program_verify
  import sfpv_pkg::*;
#(
  parameter int PAGE_BYTES   = 256,
  parameter int SECTOR_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sfpv_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output sfpv_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [24:0] cfg_wdata
);

  localparam int PA_W = $clog2(PAGE_BYTES);
  localparam int PC_W = $clog2(PAGE_BYTES + 1);
  localparam int BI_W = $clog2(PAGE_BYTES + 5);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_E_WEN, PH_ERASE, PH_E_POLL, PH_E_GAP, PH_FILL,
    PH_P_WEN, PH_PROG, PH_P_POLL, PH_P_GAP, PH_READ, PH_SLEEP
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [23:0]      addr_r, addr_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [BI_W-1:0]  bi_r, bi_nxt;
  logic [7:0]       so_r, so_nxt;
  logic [7:0]       si_r, si_nxt;
  logic [2:0]       bc_r, bc_nxt;
  logic             hb_r, hb_nxt;
  logic [23:0]      pt_r, pt_nxt;
  logic             mis_r, mis_nxt;
  logic             cs_r, cs_nxt, ck_r, ck_nxt, dt_r, dt_nxt;
  logic [24:0]      len_cfg_r;
  logic [23:0]      gap_cfg_r;

  logic             acc;
  logic             verify, done;
  logic [7:0]       ram_rdata;
  logic             ram_we;
  logic [PA_W-1:0]  ram_raddr;
  logic [BI_W-1:0]  rd_idx;
  sfpv_out_t        res;
  sfpv_out_t        out_r, skid_r;
  logic             out_v_r, skid_v_r;
  logic             out_fire, out_busy;

  assign acc = in_valid && !in_stall;

  // Page buffer, read address follows the next byte index so data lines up
  assign ram_we = acc && (in_data.action == ACT_BYTE) && (phase_r == PH_FILL) &&
                  (BI_W'(pc_r) > bi_r) && (bi_r < BI_W'(PAGE_BYTES));
  assign rd_idx    = bi_nxt - BI_W'(4);
  assign ram_raddr = rd_idx[PA_W-1:0];

  sfpv_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bi_r[PA_W-1:0]),
    .wdata (in_data.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    logic [24:0]     len;
    logic [BI_W-1:0] clen;
    logic [7:0]      op;
    logic [7:0]      tx;
    logic [24:0]     nx;
    logic [24:0]     rem;
    logic            do_sp;
    logic [23:0]     sp_addr;
    phase_t          ent;
    logic            do_ent;

    len = (len_cfg_r > ADDR_LIMIT) ? ADDR_LIMIT : len_cfg_r;
    phase_nxt = phase_r; addr_nxt = addr_r; pc_nxt = pc_r; bi_nxt = bi_r;
    so_nxt = so_r; si_nxt = si_r; bc_nxt = bc_r; hb_nxt = hb_r; pt_nxt = pt_r;
    mis_nxt = mis_r; cs_nxt = cs_r; ck_nxt = ck_r; dt_nxt = dt_r;
    verify = 1'b0; done = 1'b0;
    do_sp = 1'b0; sp_addr = addr_r; ent = phase_r; do_ent = 1'b0;
    op = OP_DP; tx = 8'h00; nx = 25'd0; rem = 25'd0;

    unique case (phase_r)
      PH_ERASE:             clen = BI_W'(4);
      PH_E_POLL, PH_P_POLL: clen = BI_W'(2);
      PH_PROG, PH_READ:     clen = BI_W'(pc_r) + BI_W'(4);
      default:              clen = BI_W'(1);
    endcase

    unique case (phase_r)
      PH_WAKE:             op = OP_RES;
      PH_E_WEN, PH_P_WEN:  op = OP_WREN;
      PH_ERASE:            op = OP_SE;
      PH_E_POLL, PH_P_POLL: op = OP_RDSR;
      PH_PROG:             op = OP_PP;
      PH_READ:             op = OP_READ;
      default:             op = OP_DP;
    endcase

    // Byte to transmit at position bi_r
    if (bi_r == '0) begin
      tx = op;
    end else if (phase_r == PH_E_POLL || phase_r == PH_P_POLL) begin
      tx = 8'h00;
    end else if (bi_r == BI_W'(1)) begin
      tx = addr_r[23:16];
    end else if (bi_r == BI_W'(2)) begin
      tx = addr_r[15:8];
    end else if (bi_r == BI_W'(3)) begin
      tx = addr_r[7:0];
    end else if (phase_r == PH_PROG) begin
      tx = ram_rdata;
    end

    if (acc) begin
      unique case (in_data.action)
        ACT_START: begin
          if (phase_r == PH_IDLE) begin
            addr_nxt = '0; mis_nxt = 1'b0;
            ent = PH_WAKE; do_ent = 1'b1;
          end
        end
        ACT_BYTE: begin
          if (ram_we) begin
            bi_nxt = bi_r + BI_W'(1);
            if (bi_nxt >= BI_W'(pc_r)) begin
              ent = PH_P_WEN; do_ent = 1'b1;
            end
          end
        end
        ACT_TICK: begin
          if (phase_r == PH_IDLE || phase_r == PH_FILL) begin
            cs_nxt = 1'b1; ck_nxt = 1'b0; dt_nxt = 1'b0;
          end else if (phase_r == PH_E_GAP || phase_r == PH_P_GAP) begin
            cs_nxt = 1'b1; ck_nxt = 1'b0; dt_nxt = 1'b0;
            if (pt_r == '0) begin
              ent = (phase_r == PH_E_GAP) ? PH_E_POLL : PH_P_POLL; do_ent = 1'b1;
            end else begin
              pt_nxt = pt_r - 24'd1;
            end
          end else if (bi_r >= clen) begin
            // Deselect tick, then decide on the next command
            cs_nxt = 1'b1; ck_nxt = 1'b0; dt_nxt = 1'b0;
            unique case (phase_r)
              PH_WAKE: begin
                addr_nxt = '0;
                ent = (len != '0) ? PH_E_WEN : PH_SLEEP; do_ent = 1'b1;
              end
              PH_E_WEN: begin ent = PH_ERASE;  do_ent = 1'b1; end
              PH_ERASE: begin ent = PH_E_POLL; do_ent = 1'b1; end
              PH_P_WEN: begin ent = PH_PROG;   do_ent = 1'b1; end
              PH_PROG:  begin ent = PH_P_POLL; do_ent = 1'b1; end
              PH_E_POLL, PH_P_POLL: begin
                if (si_r[0]) begin
                  pt_nxt = gap_cfg_r;
                  ent = (phase_r == PH_E_POLL) ? PH_E_GAP : PH_P_GAP; do_ent = 1'b1;
                end else if (phase_r == PH_P_POLL) begin
                  ent = PH_READ; do_ent = 1'b1;
                end else begin
                  nx = {1'b0, addr_r} + 25'(SECTOR_BYTES);
                  if (nx < len) begin
                    addr_nxt = nx[23:0];
                    ent = PH_E_WEN; do_ent = 1'b1;
                  end else begin
                    addr_nxt = '0; sp_addr = '0; do_sp = 1'b1;
                  end
                end
              end
              PH_READ: begin
                if (mis_r) begin
                  mis_nxt = 1'b0; verify = 1'b1;
                  ent = PH_P_WEN; do_ent = 1'b1;
                end else begin
                  nx = {1'b0, addr_r} + 25'(pc_r);
                  if (nx >= len) begin
                    ent = PH_SLEEP; do_ent = 1'b1;
                  end else begin
                    addr_nxt = nx[23:0]; sp_addr = nx[23:0]; do_sp = 1'b1;
                  end
                end
              end
              default: begin
                ent = PH_IDLE; do_ent = 1'b1; done = 1'b1;
              end
            endcase
          end else if (!hb_r) begin
            // First half of a bit: drive data, sample miso
            if (bc_r == 3'd7) begin
              so_nxt = tx;
            end
            si_nxt[bc_r] = in_data.miso;
            cs_nxt = 1'b0; ck_nxt = 1'b0; dt_nxt = so_nxt[bc_r];
            hb_nxt = 1'b1;
          end else begin
            // Second half: clock high, advance bit and byte
            cs_nxt = 1'b0; ck_nxt = 1'b1;
            hb_nxt = 1'b0;
            if (bc_r == 3'd0) begin
              bc_nxt = 3'd7;
              if (phase_r == PH_READ && bi_r >= BI_W'(4) &&
                  (bi_r - BI_W'(4)) < BI_W'(PAGE_BYTES) && ram_rdata != si_r) begin
                mis_nxt = 1'b1;
              end
              bi_nxt = bi_r + BI_W'(1);
            end else begin
              bc_nxt = bc_r - 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Start of a page: sleep when past the image, else fill up to a page
    if (do_sp) begin
      if ({1'b0, sp_addr} >= len) begin
        ent = PH_SLEEP;
      end else begin
        rem = len - {1'b0, sp_addr};
        pc_nxt = (rem > 25'(PAGE_BYTES)) ? PC_W'(PAGE_BYTES) : rem[PC_W-1:0];
        ent = PH_FILL;
      end
      do_ent = 1'b1;
    end

    if (do_ent) begin
      phase_nxt = ent; bi_nxt = '0; bc_nxt = 3'd7; hb_nxt = 1'b0;
    end
  end

  // Result word
  always_comb begin
    res.cs_n          = cs_nxt;
    res.sclk          = ck_nxt;
    res.mosi          = dt_nxt;
    res.want_byte     = (phase_nxt == PH_FILL) && (bi_nxt < BI_W'(pc_nxt));
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done;
    res.verify_failed = verify;
  end

  // State registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; addr_r <= '0; pc_r <= '0; bi_r <= '0;
      so_r <= '0; si_r <= '0; bc_r <= 3'd7; hb_r <= 1'b0; pt_r <= '0;
      mis_r <= 1'b0; cs_r <= 1'b1; ck_r <= 1'b0; dt_r <= 1'b0;
      len_cfg_r <= '0; gap_cfg_r <= 24'd1000;
    end else begin
      phase_r <= phase_nxt; addr_r <= addr_nxt; pc_r <= pc_nxt; bi_r <= bi_nxt;
      so_r <= so_nxt; si_r <= si_nxt; bc_r <= bc_nxt; hb_r <= hb_nxt; pt_r <= pt_nxt;
      mis_r <= mis_nxt; cs_r <= cs_nxt; ck_r <= ck_nxt; dt_r <= dt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_LENGTH: len_cfg_r <= cfg_wdata;
          REG_POLL_GAP:     gap_cfg_r <= cfg_wdata[23:0];
        endcase
      end
    end
  end

  // Output register with skid stage
  assign out_fire = out_v_r && !out_stall;
  assign out_busy = out_v_r && !out_fire;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_fire) begin
        out_v_r  <= skid_v_r;
        skid_v_r <= 1'b0;
      end
      if (acc) begin
        if (out_busy) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire && skid_v_r) begin
      out_r <= skid_r;
    end
    if (acc) begin
      if (out_busy) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> rtl/sfpv_chk.sv
// Port checker for the SPI flash programmer, bound to the top level.
// Depends on sfpv_pkg.
module sfpv_chk
  import sfpv_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input sfpv_out_t out_data
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // Completion ends the run
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && out_data.cs_n)
    else $error("done while busy");

  // Verify failure only inside a run
  a_verify: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verify_failed |-> out_data.busy_res && !out_data.done_res)
    else $error("verify failure outside a run");

  // Idle bus: data low while deselected
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cs_n |-> !out_data.mosi && !out_data.sclk)
    else $error("bus active while deselected");

  // Byte requests only while busy with flash deselected
  a_want: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.want_byte |-> out_data.busy_res && out_data.cs_n)
    else $error("byte request outside fill");

endmodule

bind spi_flash_program_verify sfpv_chk u_sfpv_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/spi_flash_program_verify_tb.sv
// Testbench for spi_flash_program_verify: drives start, tick and image byte words, predicts
// every result word in-bench and checks them in order. Depends on sfpv_pkg and the RTL.
module spi_flash_program_verify_tb;
  import sfpv_pkg::*;

  localparam int PAGE_SZ   = 256;
  localparam int SECTOR_SZ = 65536;
  localparam int STALL_LIMIT = 5000;

  typedef enum logic [3:0] {
    S_IDLE, S_WAKE, S_E_WEN, S_ERASE, S_E_POLL, S_E_GAP, S_FILL,
    S_P_WEN, S_PROG, S_P_POLL, S_P_GAP, S_READ, S_SLEEP
  } seq_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sfpv_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sfpv_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_IMAGE_LENGTH;
  logic [24:0] cfg_wdata = '0;

  spi_flash_program_verify uut (.*);

  always #4 clk = ~clk;

  // Predicted programmer state
  logic [24:0] len_reg;
  logic [23:0] gap_reg;
  seq_t        seq;
  logic [24:0] addr;
  logic [7:0]  page_buf [PAGE_SZ];
  logic [8:0]  page_len;
  logic [8:0]  bidx;
  logic [7:0]  sh_out, sh_in;
  logic [2:0]  bcnt;
  logic        half;
  logic [23:0] gap_cnt;
  logic        miscompare;
  logic        cs_q, clk_q, dat_q;

  sfpv_out_t pending_words [$];
  int errors = 0;
  int items_sent = 0;
  int in_idle_pct = 0, out_idle_pct = 0;
  int busy_pct = 30;
  bit corrupt_next = 0;
  int quiet_cycles = 0;

  function automatic logic [24:0] used_len();
    return (len_reg > ADDR_LIMIT) ? ADDR_LIMIT : len_reg;
  endfunction

  function automatic void go(seq_t s);
    seq = s; bidx = 0; bcnt = 3'd7; half = 1'b0;
  endfunction

  function automatic void next_page();
    logic [24:0] rem;
    if (addr >= used_len()) begin
      go(S_SLEEP);
      return;
    end
    rem = used_len() - addr;
    page_len = (rem > PAGE_SZ) ? 9'(PAGE_SZ) : rem[8:0];
    go(S_FILL);
  endfunction

  function automatic int frame_bytes(seq_t s);
    case (s)
      S_ERASE: return 4;
      S_E_POLL, S_P_POLL: return 2;
      S_PROG, S_READ: return 4 + page_len;
      default: return 1;
    endcase
  endfunction

  function automatic logic [7:0] frame_byte(seq_t s, int k);
    logic [7:0] op;
    case (s)
      S_WAKE: op = OP_RES;
      S_E_WEN, S_P_WEN: op = OP_WREN;
      S_ERASE: op = OP_SE;
      S_E_POLL, S_P_POLL: op = OP_RDSR;
      S_PROG: op = OP_PP;
      S_READ: op = OP_READ;
      default: op = OP_DP;
    endcase
    if (k == 0) return op;
    if (s == S_E_POLL || s == S_P_POLL) return 8'h00;
    if (k < 4) return 8'(addr >> (8 * (3 - k)));
    if (s == S_PROG) return page_buf[k - 4];
    return 8'h00;
  endfunction

  // End of a command frame: choose what follows
  function automatic void end_frame(ref logic vf, ref logic dn);
    logic [25:0] nxt;
    case (seq)
      S_WAKE: begin
        addr = '0;
        go(used_len() > 0 ? S_E_WEN : S_SLEEP);
      end
      S_E_WEN: go(S_ERASE);
      S_ERASE: go(S_E_POLL);
      S_P_WEN: go(S_PROG);
      S_PROG:  go(S_P_POLL);
      S_E_POLL, S_P_POLL: begin
        if (sh_in[0]) begin
          gap_cnt = gap_reg;
          go(seq == S_E_POLL ? S_E_GAP : S_P_GAP);
        end else if (seq == S_P_POLL) begin
          go(S_READ);
        end else begin
          nxt = 26'(addr) + 26'(SECTOR_SZ);
          if (nxt < used_len()) begin
            addr = nxt[24:0];
            go(S_E_WEN);
          end else begin
            addr = '0;
            next_page();
          end
        end
      end
      S_READ: begin
        if (miscompare) begin
          miscompare = 1'b0;
          vf = 1'b1;
          go(S_P_WEN);
        end else begin
          nxt = 26'(addr) + 26'(page_len);
          if (nxt >= used_len()) go(S_SLEEP);
          else begin
            addr = nxt[24:0];
            next_page();
          end
        end
      end
      default: begin
        go(S_IDLE);
        dn = 1'b1;
      end
    endcase
  endfunction

  // One half-bit of the serial link
  function automatic void half_bit_tick(logic miso, ref logic vf, ref logic dn);
    if (seq == S_IDLE || seq == S_FILL) begin
      {cs_q, clk_q, dat_q} = 3'b100;
    end else if (seq == S_E_GAP || seq == S_P_GAP) begin
      {cs_q, clk_q, dat_q} = 3'b100;
      if (gap_cnt == 0) go(seq == S_E_GAP ? S_E_POLL : S_P_POLL);
      else gap_cnt--;
    end else if (bidx >= frame_bytes(seq)) begin
      {cs_q, clk_q, dat_q} = 3'b100;
      end_frame(vf, dn);
    end else if (!half) begin
      if (bcnt == 3'd7) sh_out = frame_byte(seq, bidx);
      sh_in[bcnt] = miso;
      {cs_q, clk_q, dat_q} = {2'b00, sh_out[bcnt]};
      half = 1'b1;
    end else begin
      cs_q = 1'b0; clk_q = 1'b1;
      half = 1'b0;
      if (bcnt == 0) begin
        bcnt = 3'd7;
        if (seq == S_READ && bidx >= 4 && page_buf[bidx - 4] != sh_in) miscompare = 1'b1;
        bidx++;
      end else begin
        bcnt--;
      end
    end
  endfunction

  function automatic sfpv_out_t predict_word(sfpv_in_t w);
    sfpv_out_t r;
    logic vf, dn;
    vf = 1'b0; dn = 1'b0;
    case (w.action)
      ACT_START: if (seq == S_IDLE) begin
        addr = '0; miscompare = 1'b0;
        go(S_WAKE);
      end
      ACT_BYTE: if (seq == S_FILL && bidx < page_len) begin
        page_buf[bidx] = w.data_byte;
        bidx++;
        if (bidx >= page_len) go(S_P_WEN);
      end
      ACT_TICK: half_bit_tick(w.miso, vf, dn);
      default: ;
    endcase
    r.cs_n = cs_q; r.sclk = clk_q; r.mosi = dat_q;
    r.want_byte = (seq == S_FILL && bidx < page_len);
    r.busy_res = (seq != S_IDLE);
    r.done_res = dn;
    r.verify_failed = vf;
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch %s", msg);
    errors++;
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    sfpv_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected result word %b", out_data));
      end else begin
        want = pending_words.pop_front();
        if (out_data.cs_n !== want.cs_n)
          report($sformatf("cs_n: got %b, expected %b", out_data.cs_n, want.cs_n));
        if (out_data.sclk !== want.sclk)
          report($sformatf("sclk: got %b, expected %b", out_data.sclk, want.sclk));
        if (out_data.mosi !== want.mosi)
          report($sformatf("mosi: got %b, expected %b", out_data.mosi, want.mosi));
        if (out_data.want_byte !== want.want_byte)
          report($sformatf("want_byte: got %b, expected %b",
                           out_data.want_byte, want.want_byte));
        if (out_data.busy_res !== want.busy_res)
          report($sformatf("busy_res: got %b, expected %b",
                           out_data.busy_res, want.busy_res));
        if (out_data.done_res !== want.done_res)
          report($sformatf("done_res: got %b, expected %b",
                           out_data.done_res, want.done_res));
        if (out_data.verify_failed !== want.verify_failed)
          report($sformatf("verify_failed: got %b, expected %b",
                           out_data.verify_failed, want.verify_failed));
      end
    end
    out_stall <= (out_idle_pct > 0) && ($urandom_range(0, 99) < out_idle_pct);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** spi_flash_program_verify: FAILED **");
      $finish;
    end
  end

  // Send one word, predicting its result when it is taken
  task automatic drive_word(sfpv_in_t w);
    while (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pending_words = {pending_words, predict_word(w)};
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [24:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_LENGTH) len_reg = val;
    else gap_reg = val[23:0];
  endtask

  // Pick the miso level the flash would return, with busy polls and rare bad reads
  function automatic logic flash_miso();
    logic b;
    b = 1'($urandom_range(0, 1));
    if (half) return b;
    if ((seq == S_E_POLL || seq == S_P_POLL) && bidx == 1 && bcnt == 0)
      return $urandom_range(0, 99) < busy_pct;
    if (seq == S_READ && bidx >= 4 && bidx < 4 + page_len) begin
      b = page_buf[bidx - 4][bcnt];
      if (corrupt_next || $urandom_range(0, 3999) == 0) begin
        corrupt_next = 0;
        b = ~b;
      end
    end
    return b;
  endfunction

  // A whole programming run, with occasional noise words
  task automatic run_sequence(int noise_pct);
    sfpv_in_t w;
    w = '{ACT_START, 8'($urandom), 1'($urandom)};
    drive_word(w);
    while (seq != S_IDLE) begin
      w.data_byte = 8'($urandom);
      w.miso = flash_miso();
      if ($urandom_range(0, 99) < noise_pct) w.action = 2'($urandom_range(1, 3));
      else if (seq == S_FILL && bidx < page_len) w.action = ACT_BYTE;
      else w.action = ACT_TICK;
      drive_word(w);
    end
  endtask

  task automatic test_idle_words();
    sfpv_in_t w;
    write_reg(REG_IMAGE_LENGTH, 25'h1FF_FFFF);
    write_reg(REG_POLL_GAP, 25'hFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      w = '{2'(i % 4 == 2 ? 3 : i % 4), 8'($urandom), 1'(i)};
      drive_word(w);
    end
  endtask

  // Zero length: wake then straight to power-down; huge poll gap is never used
  task automatic test_zero_length();
    write_reg(REG_IMAGE_LENGTH, 25'd0);
    run_sequence(0);
    run_sequence(10);
  endtask

  task automatic test_verify_retry();
    write_reg(REG_IMAGE_LENGTH, 25'd1);
    write_reg(REG_POLL_GAP, 25'd1);
    corrupt_next = 1;
    run_sequence(0);
  endtask

  task automatic test_random(int in_pct, int out_pct, int target);
    int stop_at;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      write_reg(REG_IMAGE_LENGTH, 25'($urandom_range(0, 2)));
      write_reg(REG_POLL_GAP, 25'($urandom_range(0, 3)));
      run_sequence(5);
    end
  endtask

  initial begin
    len_reg = '0; gap_reg = 24'd1000;
    addr = '0; page_len = '0; sh_out = '0; sh_in = '0;
    gap_cnt = '0; miscompare = 1'b0;
    {cs_q, clk_q, dat_q} = 3'b100;
    foreach (page_buf[i]) page_buf[i] = '0;
    go(S_IDLE);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_words();
    test_zero_length();
    test_verify_retry();
    test_random(35, 57, 120);
    test_random(57, 35, 120);
    test_random(0, 0, 120);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("** spi_flash_program_verify: PASSED **");
    else $display("** spi_flash_program_verify: FAILED **");
    $finish;
  end

endmodule
